@@ sv/btda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_pkg
// Shared sizes, character codes, queue entry type and the decimal doubling
// step for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package btda_pkg;

	localparam int DIGIT_COUNT = 20;
	localparam int VALUE_WIDTH = 64;
	localparam int IN_WIDTH    = 64;
	localparam int CODE_WIDTH  = 6;
	localparam int BCD_WIDTH   = DIGIT_COUNT * 4;
	localparam int REM_WIDTH   = $clog2(DIGIT_COUNT + 1);
	localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CODE_WIDTH-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CODE_WIDTH-1:0] CHAR_MINUS = 6'd45;

	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED   = 1'b1;

	// classified item handed from front to back
	typedef struct packed {
		logic                   negative;
		logic [VALUE_WIDTH-1:0] magnitude;
	} entry_t;

	// one shift-add-3 step: correct each digit, then shift in the next bit
	function automatic logic [BCD_WIDTH-1:0] dabble(input logic [BCD_WIDTH-1:0] bcd,
							input logic bit_in);
		logic [BCD_WIDTH-1:0] adj;
		adj = bcd;
		for (int d = 0; d < DIGIT_COUNT; d++) begin
			if (bcd[d*4 +: 4] >= 4'd5) begin
				adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
			end
		end
		return {adj[BCD_WIDTH-2:0], bit_in};
	endfunction

endpackage

@@ sv/btda_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_in_if
// Input channel: mode bit and raw word with valid/ready.
// ----------------------------------------------------------------------------
interface btda_in_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [btda_pkg::IN_WIDTH-1:0]  value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ sv/btda_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_out_if
// Output channel: one ascii character per transfer with a last marker.
// ----------------------------------------------------------------------------
interface btda_out_if;
	logic                             valid;
	logic                             ready;
	logic [btda_pkg::CODE_WIDTH-1:0]  char_code;
	logic                             last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ sv/btda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_front
// Accepts input words, derives sign and magnitude and holds the result in
// one register stage ahead of the queue.
// ----------------------------------------------------------------------------
module btda_front (
	input  logic               clk,
	input  logic               arst_n,
	btda_in_if.sink            item,
	output logic               push_valid,
	input  logic               push_ready,
	output btda_pkg::entry_t   push_data
);

	logic [btda_pkg::VALUE_WIDTH-1:0] raw;
	logic [btda_pkg::VALUE_WIDTH-1:0] raw_inv;
	btda_pkg::entry_t                 cls;
	btda_pkg::entry_t                 ent_s1;
	logic                             v_s1;
	logic                             take;

	// sign and magnitude of the low bits
	always_comb begin
		raw           = item.value[btda_pkg::VALUE_WIDTH-1:0];
		raw_inv       = ~raw;
		cls.negative  = (item.operation == btda_pkg::OP_SIGNED) &&
				raw[btda_pkg::VALUE_WIDTH-1];
		cls.magnitude = cls.negative ? (raw_inv + btda_pkg::VALUE_WIDTH'(1)) : raw;
	end

	assign item.ready = !v_s1 || push_ready;
	assign take       = item.valid && item.ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= cls;
		end
	end

	assign push_valid = v_s1;
	assign push_data  = ent_s1;

endmodule

@@ sv/btda_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_queue
// Short queue between front and back so either side can stall alone.
// ----------------------------------------------------------------------------
module btda_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  btda_pkg::entry_t   push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output btda_pkg::entry_t   pop_data
);

	btda_pkg::entry_t                mem_q [btda_pkg::QUEUE_DEPTH];
	logic [btda_pkg::QPTR_WIDTH-1:0] wr_q;
	logic [btda_pkg::QPTR_WIDTH-1:0] rd_q;
	logic [btda_pkg::QCNT_WIDTH-1:0] cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (cnt_q != btda_pkg::QCNT_WIDTH'(btda_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == btda_pkg::QPTR_WIDTH'(btda_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == btda_pkg::QPTR_WIDTH'(btda_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// fill count stays within depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= btda_pkg::QCNT_WIDTH'(btda_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// pointers differ by the fill count
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == btda_pkg::QCNT_WIDTH'(btda_pkg::QUEUE_DEPTH)) ==
		(wr_q == rd_q))
		else $error("queue pointers disagree with count");

endmodule

@@ sv/btda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_back
// Shift-add-3 conversion of one magnitude, leading zero skip and character
// emission through an output register.
// ----------------------------------------------------------------------------
module btda_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  btda_pkg::entry_t   pop_data,
	btda_out_if.source         chars
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                              state_q;
	logic [btda_pkg::VALUE_WIDTH-1:0]    shift_q;
	logic [btda_pkg::BCD_WIDTH-1:0]      bcd_q;
	logic                                neg_q;
	logic [btda_pkg::STEP_WIDTH-1:0]     step_q;
	logic [btda_pkg::REM_WIDTH-1:0]      rem_q;
	logic                                out_v_q;
	logic [btda_pkg::CODE_WIDTH-1:0]     out_code_q;
	logic                                out_last_q;
	logic                                slot_free;
	logic                                load_out;
	logic [3:0]                          top_digit;

	assign slot_free = !out_v_q || chars.ready;
	assign load_out  = (state_q == ST_SIGN || state_q == ST_EMIT) && slot_free;
	assign top_digit = bcd_q[btda_pkg::BCD_WIDTH-1 -: 4];
	assign pop_ready = (state_q == ST_IDLE);

	assign chars.valid     = out_v_q;
	assign chars.char_code = out_code_q;
	assign chars.last      = out_last_q;

	// sequencer with registered output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			shift_q    <= '0;
			bcd_q      <= '0;
			neg_q      <= 1'b0;
			step_q     <= '0;
			rem_q      <= '0;
			out_v_q    <= 1'b0;
			out_code_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			// output register: load a character or drain on transfer
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (chars.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						shift_q <= pop_data.magnitude;
						neg_q   <= pop_data.negative;
						bcd_q   <= '0;
						step_q  <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q   <= btda_pkg::dabble(bcd_q,
						shift_q[btda_pkg::VALUE_WIDTH-1]);
					shift_q <= {shift_q[btda_pkg::VALUE_WIDTH-2:0], 1'b0};
					step_q  <= step_q + 1'b1;
					if (step_q == btda_pkg::STEP_WIDTH'(btda_pkg::VALUE_WIDTH - 1)) begin
						rem_q   <= btda_pkg::REM_WIDTH'(btda_pkg::DIGIT_COUNT);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keep at least one digit
					if (top_digit == 4'd0 && rem_q > btda_pkg::REM_WIDTH'(1)) begin
						bcd_q <= {bcd_q[btda_pkg::BCD_WIDTH-5:0], 4'd0};
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						out_code_q <= btda_pkg::CHAR_MINUS;
						out_last_q <= 1'b0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_code_q <= btda_pkg::CHAR_ZERO +
							btda_pkg::CODE_WIDTH'(top_digit);
						out_last_q <= (rem_q == btda_pkg::REM_WIDTH'(1));
						bcd_q      <= {bcd_q[btda_pkg::BCD_WIDTH-5:0], 4'd0};
						rem_q      <= rem_q - 1'b1;
						if (rem_q == btda_pkg::REM_WIDTH'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the final digit returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && slot_free && rem_q == btda_pkg::REM_WIDTH'(1))
		|=> (state_q == ST_IDLE && out_v_q && out_last_q))
		else $error("last digit did not end the string");

	// digits remain whenever emitting
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_SIGN) |-> (rem_q != '0))
		else $error("emitting with no digits left");

	// sign only for negative values and never marked last
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN && slot_free) |=> (neg_q && !out_last_q &&
		out_code_q == btda_pkg::CHAR_MINUS))
		else $error("bad sign character");

endmodule

@@ sv/binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 64-bit word, unsigned or two's complement, to a decimal ascii
// string, most significant character first, one character per transfer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                  transfer when
//  item     in   operation, value[63:0]   item.valid && item.ready
//  chars    out  char_code[5:0], last     chars.valid && chars.ready
//
// An item leaves the queue, runs the shift-add-3 loop once per value bit,
// skips leading zeros and emits its characters. The back takes a new item
// only after the previous string's last character is loaded; the front
// stage and a two-entry queue keep taking items while the back converts.
// Output stalls hold the current character in its register and pause
// emission. Reset clears all control state at once; no clear pass.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	btda_in_if.sink     item,
	btda_out_if.source  chars
);

	logic             push_valid;
	logic             push_ready;
	btda_pkg::entry_t push_data;
	logic             pop_valid;
	logic             pop_ready;
	btda_pkg::entry_t pop_data;

	// classify
	btda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple
	btda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// convert and emit
	btda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.chars     (chars)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary to decimal ascii converter. Each word
// that the block takes is turned into its expected character string here, and
// every character that leaves the block is compared against the oldest one
// still pending. Directed corner words come first, then random words under
// several idle and stall patterns, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_WORDS = 120;

	typedef struct packed {
		logic [btda_pkg::CODE_WIDTH-1:0] char_code;
		logic                            last;
	} char_t;

	logic clk = 1'b0;
	logic arst_n;

	btda_in_if  item_if ();
	btda_out_if chars_if ();

	binary_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.chars  (chars_if)
	);

	char_t pending_chars[$];
	int    send_idle_pct = 0;
	int    sink_stall_pct = 0;
	int    hold_requests = 0;
	int    hold_served = 0;
	int    hold_left = 0;
	int    mismatches = 0;
	int    words_sent = 0;
	int    signed_words = 0;
	int    negative_words = 0;
	int    chars_seen = 0;
	int    quiet_cycles = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// build the expected string for one word
	function automatic void queue_decimal_string(input logic op,
						     input logic [btda_pkg::IN_WIDTH-1:0] word);
		logic [btda_pkg::VALUE_WIDTH-1:0] raw;
		logic [btda_pkg::VALUE_WIDTH-1:0] mag;
		logic [btda_pkg::VALUE_WIDTH-1:0] rem;
		logic                             neg;
		logic [3:0]                       digits [btda_pkg::DIGIT_COUNT];
		int                               top;
		char_t                            c;
		raw = word[btda_pkg::VALUE_WIDTH-1:0];
		neg = (op == btda_pkg::OP_SIGNED) && raw[btda_pkg::VALUE_WIDTH-1];
		// two's complement negate also gives the right magnitude for the most negative value
		mag = neg ? (~raw + 1'b1) : raw;
		for (int d = 0; d < btda_pkg::DIGIT_COUNT; d++) begin
			rem = mag % btda_pkg::VALUE_WIDTH'(10);
			digits[d] = rem[3:0];
			mag = mag / btda_pkg::VALUE_WIDTH'(10);
		end
		top = btda_pkg::DIGIT_COUNT - 1;
		while (top > 0 && digits[top] == 4'd0) begin
			top--;
		end
		if (neg) begin
			c.char_code = btda_pkg::CHAR_MINUS;
			c.last = 1'b0;
			pending_chars.push_back(c);
		end
		for (int d = top; d >= 0; d--) begin
			c.char_code = btda_pkg::CHAR_ZERO + btda_pkg::CODE_WIDTH'(digits[d]);
			c.last = (d == 0);
			pending_chars.push_back(c);
		end
	endfunction

	// offer one word, hold it until the transfer, then predict its string
	task automatic offer_word(input logic op, input logic [btda_pkg::IN_WIDTH-1:0] word);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_if.valid = 1'b0;
			@(negedge clk);
		end
		item_if.valid = 1'b1;
		item_if.operation = op;
		item_if.value = word;
		do begin
			@(posedge clk);
		end while (!item_if.ready);
		queue_decimal_string(op, word);
		words_sent++;
		if (op == btda_pkg::OP_SIGNED) begin
			signed_words++;
			if (word[btda_pkg::VALUE_WIDTH-1]) begin
				negative_words++;
			end
		end
	endtask

	// output side: long hold-off on request, otherwise random stalls
	initial begin
		chars_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				chars_if.ready = 1'b0;
				hold_left--;
			end else begin
				chars_if.ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// compare each character transfer with the oldest pending one
	always @(posedge clk) begin
		char_t want;
		if (arst_n && chars_if.valid && chars_if.ready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				$error("unexpected character: char_code %0d last %0b",
				       chars_if.char_code, chars_if.last);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (chars_if.char_code !== want.char_code) begin
					$error("char_code mismatch: expected %0d, got %0d",
					       want.char_code, chars_if.char_code);
					mismatches++;
				end
				if (chars_if.last !== want.last) begin
					$error("last mismatch: expected %0b, got %0b",
					       want.last, chars_if.last);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (item_if.valid && item_if.ready) ||
		    (chars_if.valid && chars_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// corner words: zeros, digit boundaries, full width, signed extremes
	task automatic test_directed();
		logic [btda_pkg::IN_WIDTH-1:0] ten_pow;
		ten_pow = 64'd1;
		repeat (19) ten_pow = ten_pow * 64'd10;
		offer_word(btda_pkg::OP_UNSIGNED, 64'd0);
		offer_word(btda_pkg::OP_SIGNED, 64'd0);
		offer_word(btda_pkg::OP_UNSIGNED, 64'd1);
		offer_word(btda_pkg::OP_UNSIGNED, 64'd9);
		offer_word(btda_pkg::OP_UNSIGNED, 64'd10);
		offer_word(btda_pkg::OP_UNSIGNED, 64'd99);
		offer_word(btda_pkg::OP_SIGNED, 64'd100);
		offer_word(btda_pkg::OP_UNSIGNED, ten_pow - 64'd1);
		offer_word(btda_pkg::OP_UNSIGNED, ten_pow);
		offer_word(btda_pkg::OP_UNSIGNED, {64{1'b1}});
		offer_word(btda_pkg::OP_UNSIGNED, 64'h8000_0000_0000_0000);
		offer_word(btda_pkg::OP_SIGNED, {64{1'b1}});
		offer_word(btda_pkg::OP_SIGNED, 64'h8000_0000_0000_0000);
		offer_word(btda_pkg::OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
		offer_word(btda_pkg::OP_SIGNED, -64'sd10);
		offer_word(btda_pkg::OP_SIGNED, 64'h8000_0000_0000_0001);
		offer_word(btda_pkg::OP_UNSIGNED, 64'h5555_5555_5555_5555);
		offer_word(btda_pkg::OP_SIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	// random words: full width, short lengths, near powers of ten, negatives of random length
	task automatic run_random_words(input int count);
		logic [btda_pkg::IN_WIDTH-1:0] word;
		logic [btda_pkg::IN_WIDTH-1:0] ten_pow;
		logic                          op;
		repeat (count) begin
			op = 1'($urandom_range(1));
			case ($urandom_range(3))
				0: begin
					word = {$urandom, $urandom};
				end
				1: begin
					word = {$urandom, $urandom} >> $urandom_range(63);
				end
				2: begin
					ten_pow = 64'd1;
					repeat ($urandom_range(19)) ten_pow = ten_pow * 64'd10;
					word = ten_pow + 64'($urandom_range(2)) - 64'd1;
				end
				default: begin
					word = -({$urandom, $urandom} >> $urandom_range(63));
					op = btda_pkg::OP_SIGNED;
				end
			endcase
			offer_word(op, word);
		end
	endtask

	task automatic test_steady_flow();
		send_idle_pct = 0;
		sink_stall_pct = 0;
		run_random_words(PHASE_WORDS);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 55;
		sink_stall_pct = 0;
		run_random_words(PHASE_WORDS);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		sink_stall_pct = 55;
		run_random_words(PHASE_WORDS);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 10;
		sink_stall_pct = 10;
		run_random_words(PHASE_WORDS);
	endtask

	// output held off while words keep coming, so the input must stall
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		sink_stall_pct = 0;
		hold_requests++;
		run_random_words(10);
	endtask

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.operation = btda_pkg::OP_UNSIGNED;
		item_if.value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_steady_flow();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_output_backpressure();

		// drain
		@(negedge clk);
		item_if.valid = 1'b0;
		sink_stall_pct = 0;
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d words (%0d signed, %0d of them negative)",
			 words_sent, signed_words, negative_words);
		$display("checked %0d characters under gaps, stalls and a long output hold-off",
			 chars_seen);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d characters never arrived",
				 mismatches, pending_chars.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
